>>> src/pie_pkg.sv
// Types, constants and the control-store program of the pseudo-instruction expander.
package pie_pkg;

   localparam int PC_W = 5;

   typedef enum logic [3:0] {
      ACT_DIV   = 4'd0,
      ACT_DIVU  = 4'd1,
      ACT_REM   = 4'd2,
      ACT_REMU  = 4'd3,
      ACT_MUL   = 4'd4,
      ACT_MULO  = 4'd5,
      ACT_MULOU = 4'd6,
      ACT_SLE   = 4'd7,
      ACT_SLEU  = 4'd8,
      ACT_SGT   = 4'd9,
      ACT_SGTU  = 4'd10,
      ACT_SGE   = 4'd11,
      ACT_SGEU  = 4'd12,
      ACT_SEQ   = 4'd13,
      ACT_SNE   = 4'd14
   } action_type;

   typedef enum logic [3:0] {
      OP_SLL   = 4'd0,
      OP_BREAK = 4'd1,
      OP_BNE   = 4'd2,
      OP_BEQ   = 4'd3,
      OP_ORI   = 4'd4,
      OP_DIV   = 4'd5,
      OP_DIVU  = 4'd6,
      OP_MFLO  = 4'd7,
      OP_MFHI  = 4'd8,
      OP_MULT  = 4'd9,
      OP_MULTU = 4'd10,
      OP_SRA   = 4'd11,
      OP_SLT   = 4'd12,
      OP_SLTU  = 4'd13
   } opcode_type;

   // How the opcode of a step is formed: fixed, or picked by the pseudo-op.
   typedef enum logic [1:0] {
      OPM_FIXED,
      OPM_DIV,
      OPM_MOVE,
      OPM_SET
   } op_mode_type;

   typedef enum logic [2:0] {
      REG_ZERO,
      REG_ONE,
      REG_DEST,
      REG_SRCA,
      REG_SRCB,
      REG_CMPL,
      REG_CMPR
   } reg_sel_type;

   typedef enum logic [2:0] {
      IMM_ZERO,
      IMM_ONE,
      IMM_BRANCH,
      IMM_ORI_FIRST,
      IMM_ORI_SECOND
   } imm_sel_type;

   typedef enum logic [1:0] {
      END_NEVER,
      END_ALWAYS,
      END_IF_RD_ZERO
   } end_mode_type;

   typedef struct packed {
      opcode_type        op;
      op_mode_type       op_mode;
      reg_sel_type       rd_sel;
      reg_sel_type       rs_sel;
      reg_sel_type       rt_sel;
      logic              sh31;
      imm_sel_type       imm_sel;
      end_mode_type      end_mode;
      logic              jump;
      logic [PC_W-1:0]   target;
   } ucode_type;

   localparam logic [15:0] BRANCH_IMM = 16'd12;
   localparam logic [4:0]  SPREAD_SHAMT = 5'd31;

   // Program entry points and jump targets.
   localparam logic [PC_W-1:0] PC_DIV_TRAP  = 5'd0;
   localparam logic [PC_W-1:0] PC_DIV_OP    = 5'd3;
   localparam logic [PC_W-1:0] PC_MUL       = 5'd5;
   localparam logic [PC_W-1:0] PC_MULO      = 5'd6;
   localparam logic [PC_W-1:0] PC_TRAP_NOP  = 5'd11;
   localparam logic [PC_W-1:0] PC_MUL_MOVE  = 5'd13;
   localparam logic [PC_W-1:0] PC_MULOU     = 5'd14;
   localparam logic [PC_W-1:0] PC_SET_LE    = 5'd17;
   localparam logic [PC_W-1:0] PC_SET_OP    = 5'd21;
   localparam logic [PC_W-1:0] PC_SET_EQ    = 5'd22;
   localparam logic [PC_W-1:0] PC_LAST      = 5'd26;

   function automatic ucode_type uc(opcode_type op, op_mode_type m, reg_sel_type rd,
                                    reg_sel_type rs, reg_sel_type rt, logic sh31,
                                    imm_sel_type imm, end_mode_type e, logic jump,
                                    logic [PC_W-1:0] target);
      ucode_type w;
      w.op       = op;
      w.op_mode  = m;
      w.rd_sel   = rd;
      w.rs_sel   = rs;
      w.rt_sel   = rt;
      w.sh31     = sh31;
      w.imm_sel  = imm;
      w.end_mode = e;
      w.jump     = jump;
      w.target   = target;
      return w;
   endfunction

   function automatic ucode_type ucode_rom(logic [PC_W-1:0] pc);
      ucode_type w;
      unique case (pc)
         // Divide group: optional zero-divisor trap, divide, result move.
         5'd0:  w = uc(OP_BNE, OPM_FIXED, REG_ZERO, REG_SRCB, REG_ZERO, 1'b0, IMM_BRANCH,
                       END_NEVER, 1'b0, 5'd0);
         5'd1:  w = uc(OP_SLL, OPM_FIXED, REG_ZERO, REG_ZERO, REG_ZERO, 1'b0, IMM_ZERO,
                       END_NEVER, 1'b0, 5'd0);
         5'd2:  w = uc(OP_BREAK, OPM_FIXED, REG_ZERO, REG_ZERO, REG_ZERO, 1'b0, IMM_ZERO,
                       END_NEVER, 1'b0, 5'd0);
         5'd3:  w = uc(OP_DIV, OPM_DIV, REG_ZERO, REG_SRCA, REG_SRCB, 1'b0, IMM_ZERO,
                       END_IF_RD_ZERO, 1'b0, 5'd0);
         5'd4:  w = uc(OP_MFLO, OPM_MOVE, REG_DEST, REG_ZERO, REG_ZERO, 1'b0, IMM_ZERO,
                       END_ALWAYS, 1'b0, 5'd0);
         // Plain multiply skips straight to the final move.
         5'd5:  w = uc(OP_MULT, OPM_FIXED, REG_ZERO, REG_SRCA, REG_SRCB, 1'b0, IMM_ZERO,
                       END_IF_RD_ZERO, 1'b1, PC_MUL_MOVE);
         // Signed multiply with overflow check.
         5'd6:  w = uc(OP_MULT, OPM_FIXED, REG_ZERO, REG_SRCA, REG_SRCB, 1'b0, IMM_ZERO,
                       END_IF_RD_ZERO, 1'b0, 5'd0);
         5'd7:  w = uc(OP_MFHI, OPM_FIXED, REG_ONE, REG_ZERO, REG_ZERO, 1'b0, IMM_ZERO,
                       END_NEVER, 1'b0, 5'd0);
         5'd8:  w = uc(OP_MFLO, OPM_FIXED, REG_DEST, REG_ZERO, REG_ZERO, 1'b0, IMM_ZERO,
                       END_NEVER, 1'b0, 5'd0);
         5'd9:  w = uc(OP_SRA, OPM_FIXED, REG_DEST, REG_ZERO, REG_DEST, 1'b1, IMM_ZERO,
                       END_NEVER, 1'b0, 5'd0);
         5'd10: w = uc(OP_BEQ, OPM_FIXED, REG_ZERO, REG_ONE, REG_DEST, 1'b0, IMM_BRANCH,
                       END_NEVER, 1'b0, 5'd0);
         5'd11: w = uc(OP_SLL, OPM_FIXED, REG_ZERO, REG_ZERO, REG_ZERO, 1'b0, IMM_ZERO,
                       END_NEVER, 1'b0, 5'd0);
         5'd12: w = uc(OP_BREAK, OPM_FIXED, REG_ZERO, REG_ZERO, REG_ZERO, 1'b0, IMM_ZERO,
                       END_NEVER, 1'b0, 5'd0);
         5'd13: w = uc(OP_MFLO, OPM_FIXED, REG_DEST, REG_ZERO, REG_ZERO, 1'b0, IMM_ZERO,
                       END_ALWAYS, 1'b0, 5'd0);
         // Unsigned multiply with overflow check, sharing the trap tail.
         5'd14: w = uc(OP_MULTU, OPM_FIXED, REG_ZERO, REG_SRCA, REG_SRCB, 1'b0, IMM_ZERO,
                       END_IF_RD_ZERO, 1'b0, 5'd0);
         5'd15: w = uc(OP_MFHI, OPM_FIXED, REG_ONE, REG_ZERO, REG_ZERO, 1'b0, IMM_ZERO,
                       END_NEVER, 1'b0, 5'd0);
         5'd16: w = uc(OP_BEQ, OPM_FIXED, REG_ZERO, REG_ONE, REG_ZERO, 1'b0, IMM_BRANCH,
                       END_NEVER, 1'b1, PC_TRAP_NOP);
         // Less-or-equal and greater-or-equal compares.
         5'd17: w = uc(OP_BNE, OPM_FIXED, REG_ZERO, REG_SRCB, REG_SRCA, 1'b0, IMM_BRANCH,
                       END_NEVER, 1'b0, 5'd0);
         5'd18: w = uc(OP_ORI, OPM_FIXED, REG_ZERO, REG_ZERO, REG_DEST, 1'b0, IMM_ONE,
                       END_NEVER, 1'b0, 5'd0);
         5'd19: w = uc(OP_BEQ, OPM_FIXED, REG_ZERO, REG_ZERO, REG_ZERO, 1'b0, IMM_BRANCH,
                       END_NEVER, 1'b0, 5'd0);
         5'd20: w = uc(OP_SLL, OPM_FIXED, REG_ZERO, REG_ZERO, REG_ZERO, 1'b0, IMM_ZERO,
                       END_NEVER, 1'b0, 5'd0);
         5'd21: w = uc(OP_SLT, OPM_SET, REG_DEST, REG_CMPL, REG_CMPR, 1'b0, IMM_ZERO,
                       END_ALWAYS, 1'b0, 5'd0);
         // Equality compares.
         5'd22: w = uc(OP_BEQ, OPM_FIXED, REG_ZERO, REG_SRCB, REG_SRCA, 1'b0, IMM_BRANCH,
                       END_NEVER, 1'b0, 5'd0);
         5'd23: w = uc(OP_ORI, OPM_FIXED, REG_ZERO, REG_ZERO, REG_DEST, 1'b0, IMM_ORI_FIRST,
                       END_NEVER, 1'b0, 5'd0);
         5'd24: w = uc(OP_BEQ, OPM_FIXED, REG_ZERO, REG_ZERO, REG_ZERO, 1'b0, IMM_BRANCH,
                       END_NEVER, 1'b0, 5'd0);
         5'd25: w = uc(OP_SLL, OPM_FIXED, REG_ZERO, REG_ZERO, REG_ZERO, 1'b0, IMM_ZERO,
                       END_NEVER, 1'b0, 5'd0);
         5'd26: w = uc(OP_ORI, OPM_FIXED, REG_ZERO, REG_ZERO, REG_DEST, 1'b0, IMM_ORI_SECOND,
                       END_ALWAYS, 1'b0, 5'd0);
         default: w = uc(OP_SLL, OPM_FIXED, REG_ZERO, REG_ZERO, REG_ZERO, 1'b0, IMM_ZERO,
                         END_ALWAYS, 1'b0, 5'd0);
      endcase
      return w;
   endfunction

   // Start step of the program for a pseudo-op.
   function automatic logic [PC_W-1:0] ucode_entry(action_type act, logic rd_zero,
                                                   logic known);
      logic [PC_W-1:0] pc;
      unique case (act) inside
         ACT_DIV, ACT_DIVU, ACT_REM, ACT_REMU:
            pc = (!rd_zero && !known) ? PC_DIV_TRAP : PC_DIV_OP;
         ACT_MUL:                            pc = PC_MUL;
         ACT_MULO:                           pc = PC_MULO;
         ACT_MULOU:                          pc = PC_MULOU;
         ACT_SLE, ACT_SLEU, ACT_SGE, ACT_SGEU: pc = PC_SET_LE;
         ACT_SGT, ACT_SGTU:                  pc = PC_SET_OP;
         ACT_SEQ, ACT_SNE:                   pc = PC_SET_EQ;
         default:                            pc = PC_DIV_OP;
      endcase
      return pc;
   endfunction

endpackage

>>> src/pseudo_instruction_expander_core.sv
// Microcoded expander that turns one pseudo-op into its sequence of real instructions.
// A taken request loads the step counter; each instruction is then registered onto rsp_.
// Throughput: one instruction per cycle from the control store while the output is not
// stalled; an item expands to 0 to 8 instructions, 8 for mulo, and no new item is taken while the sequencer is busy.
// The step counter walks one control word per cycle; output stalls hold the sequencer.
// Synchronous active-high reset empties the sequencer and the output register.
module pseudo_instruction_expander_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [3:0]          req_action,
   input  logic [4:0]          req_dest_reg,
   input  logic [4:0]          req_src_a_reg,
   input  logic [4:0]          req_src_b_reg,
   input  logic                req_divisor_known,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [3:0]          rsp_opcode,
   output logic [4:0]          rsp_rd_field,
   output logic [4:0]          rsp_rs_field,
   output logic [4:0]          rsp_rt_field,
   output logic [4:0]          rsp_shift_amount,
   output logic signed [15:0]  rsp_immediate,
   output logic                rsp_last
);
   import pie_pkg::*;

   logic              busy_ff, busy_in;
   logic [PC_W-1:0]   pc_ff, pc_in;
   action_type        act_ff;
   logic [4:0]        rd_ff, rs_ff, rt_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   opcode_type        op_ff, op_in;
   logic [4:0]        rdf_ff, rdf_in, rsf_ff, rsf_in, rtf_ff, rtf_in, sh_ff, sh_in;
   logic [15:0]       imm_ff, imm_in;
   logic              last_ff, last_in;

   ucode_type         cw;
   logic              req_take;
   logic              advance;
   logic              rd_zero;
   logic              swap;
   action_type        req_act;

   function automatic logic [4:0] pick_reg(reg_sel_type sel, logic [4:0] rd, logic [4:0] ra,
                                           logic [4:0] rb, logic sw);
      logic [4:0] r;
      unique case (sel)
         REG_ZERO: r = 5'd0;
         REG_ONE:  r = 5'd1;
         REG_DEST: r = rd;
         REG_SRCA: r = ra;
         REG_SRCB: r = rb;
         REG_CMPL: r = sw ? rb : ra;
         REG_CMPR: r = sw ? ra : rb;
         default:  r = 5'd0;
      endcase
      return r;
   endfunction

   assign req_act  = action_type'(req_action);
   assign req_ready = !busy_ff;
   assign req_take = req_valid && req_ready;
   assign cw       = ucode_rom(pc_ff);
   assign advance  = busy_ff && (!rsp_valid_ff || rsp_ready);
   assign rd_zero  = (rd_ff == 5'd0);
   // Greater-than and greater-or-equal compare with the operands exchanged.
   assign swap     = (act_ff == ACT_SGT) || (act_ff == ACT_SGTU) ||
                     (act_ff == ACT_SGE) || (act_ff == ACT_SGEU);

   always_comb begin
      unique case (cw.op_mode)
         OPM_FIXED: op_in = cw.op;
         OPM_DIV:   op_in = act_ff[0] ? OP_DIVU : OP_DIV;
         OPM_MOVE:  op_in = act_ff[1] ? OP_MFHI : OP_MFLO;
         OPM_SET:   op_in = act_ff[0] ? OP_SLT : OP_SLTU;
         default:   op_in = cw.op;
      endcase
      unique case (cw.imm_sel)
         IMM_ZERO:       imm_in = 16'd0;
         IMM_ONE:        imm_in = 16'd1;
         IMM_BRANCH:     imm_in = BRANCH_IMM;
         IMM_ORI_FIRST:  imm_in = act_ff[0] ? 16'd0 : 16'd1;
         IMM_ORI_SECOND: imm_in = act_ff[0] ? 16'd1 : 16'd0;
         default:        imm_in = 16'd0;
      endcase
      unique case (cw.end_mode)
         END_NEVER:      last_in = 1'b0;
         END_ALWAYS:     last_in = 1'b1;
         END_IF_RD_ZERO: last_in = rd_zero;
         default:        last_in = 1'b1;
      endcase
      rdf_in = pick_reg(cw.rd_sel, rd_ff, rs_ff, rt_ff, swap);
      rsf_in = pick_reg(cw.rs_sel, rd_ff, rs_ff, rt_ff, swap);
      rtf_in = pick_reg(cw.rt_sel, rd_ff, rs_ff, rt_ff, swap);
      sh_in  = cw.sh31 ? SPREAD_SHAMT : 5'd0;

      busy_in = busy_ff;
      pc_in   = pc_ff;
      if (req_take) begin
         // The unused action code expands to nothing.
         busy_in = (req_action != 4'hF);
         pc_in   = ucode_entry(req_act, req_dest_reg == 5'd0, req_divisor_known);
      end else if (advance) begin
         busy_in = !last_in;
         pc_in   = cw.jump ? cw.target : pc_ff + 1'b1;
      end

      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         pc_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req_take) begin
         act_ff <= req_act;
         rd_ff  <= req_dest_reg;
         rs_ff  <= req_src_a_reg;
         rt_ff  <= req_src_b_reg;
      end
      if (advance) begin
         op_ff   <= op_in;
         rdf_ff  <= rdf_in;
         rsf_ff  <= rsf_in;
         rtf_ff  <= rtf_in;
         sh_ff   <= sh_in;
         imm_ff  <= imm_in;
         last_ff <= last_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_opcode       = op_ff;
   assign rsp_rd_field     = rdf_ff;
   assign rsp_rs_field     = rsf_ff;
   assign rsp_rt_field     = rtf_ff;
   assign rsp_shift_amount = sh_ff;
   assign rsp_immediate    = signed'(imm_ff);
   assign rsp_last         = last_ff;

   // The sequencer stops exactly when it issues the final instruction.
   assert property (@(posedge clock) disable iff (reset)
      advance && last_in |=> !busy_ff)
      else $error("sequencer still busy after final instruction");

   assert property (@(posedge clock) disable iff (reset)
      advance && !last_in |=> busy_ff && rsp_valid_ff)
      else $error("sequence ended early");

   assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> pc_ff <= PC_LAST)
      else $error("step counter outside the control store");

   // With no new item taken, the output empties once the final transaction leaves.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && last_ff && rsp_ready && !busy_ff |=> !rsp_valid_ff)
      else $error("result overlaps the previous sequence");

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for the pseudo-instruction expander core.
module testbench;
   import pie_pkg::*;

   localparam int MAX_CYCLES    = 200000;
   localparam int RANDOM_OPS    = 500;
   localparam int SETTLE_CYCLES = 20;
   localparam int QUIET_TAIL    = 40;
   localparam int MAX_REPORTS   = 10;
   localparam logic [3:0] ACT_UNUSED = 4'd15;

   typedef struct {
      logic [3:0] action;
      logic [4:0] dest;
      logic [4:0] src_a;
      logic [4:0] src_b;
      logic       known;
      logic       drain;
   } pseudo_op_type;

   typedef struct {
      opcode_type  op;
      logic [4:0]  rd;
      logic [4:0]  rs;
      logic [4:0]  rt;
      logic [4:0]  shamt;
      logic [15:0] imm;
      logic        last;
   } mips_inst_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [3:0]        req_action = '0;
   logic [4:0]        req_dest_reg = '0;
   logic [4:0]        req_src_a_reg = '0;
   logic [4:0]        req_src_b_reg = '0;
   logic              req_divisor_known = 1'b0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [3:0]        rsp_opcode;
   logic [4:0]        rsp_rd_field;
   logic [4:0]        rsp_rs_field;
   logic [4:0]        rsp_rt_field;
   logic [4:0]        rsp_shift_amount;
   logic signed [15:0] rsp_immediate;
   logic              rsp_last;

   pseudo_op_type pending_ops[$];
   mips_inst_type expected_insts[$];
   int         n_accepted = 0;
   int         n_results = 0;
   int         n_mismatches = 0;
   int         cycle_count = 0;
   int         send_gap = 0;
   int         stall_left = 0;

   pseudo_instruction_expander_core DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_action        (req_action),
      .req_dest_reg      (req_dest_reg),
      .req_src_a_reg     (req_src_a_reg),
      .req_src_b_reg     (req_src_b_reg),
      .req_divisor_known (req_divisor_known),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_opcode        (rsp_opcode),
      .rsp_rd_field      (rsp_rd_field),
      .rsp_rs_field      (rsp_rs_field),
      .rsp_rt_field      (rsp_rt_field),
      .rsp_shift_amount  (rsp_shift_amount),
      .rsp_immediate     (rsp_immediate),
      .rsp_last          (rsp_last)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic void add_inst(opcode_type op, logic [4:0] rd, logic [4:0] rs,
                                    logic [4:0] rt, logic [4:0] shamt, logic [15:0] imm);
      mips_inst_type entry;
      entry.op    = op;
      entry.rd    = rd;
      entry.rs    = rs;
      entry.rt    = rt;
      entry.shamt = shamt;
      entry.imm   = imm;
      entry.last  = 1'b0;
      expected_insts.push_back(entry);
   endfunction

   // Appends the instruction sequence that one pseudo-op expands to.
   function automatic void expand_pseudo_op(logic [3:0] act, logic [4:0] rd,
                                            logic [4:0] a, logic [4:0] b, logic known);
      int first;
      first = expected_insts.size();
      case (act) inside
         ACT_DIV, ACT_DIVU, ACT_REM, ACT_REMU: begin
            if (rd != 5'd0 && !known) begin
               add_inst(OP_BNE, 5'd0, b, 5'd0, 5'd0, BRANCH_IMM);
               add_inst(OP_SLL, 5'd0, 5'd0, 5'd0, 5'd0, 16'd0);
               add_inst(OP_BREAK, 5'd0, 5'd0, 5'd0, 5'd0, 16'd0);
            end
            add_inst((act == ACT_DIV || act == ACT_REM) ? OP_DIV : OP_DIVU,
                     5'd0, a, b, 5'd0, 16'd0);
            if (rd != 5'd0)
               add_inst((act == ACT_DIV || act == ACT_DIVU) ? OP_MFLO : OP_MFHI,
                        rd, 5'd0, 5'd0, 5'd0, 16'd0);
         end
         ACT_MUL, ACT_MULO, ACT_MULOU: begin
            add_inst(act == ACT_MULOU ? OP_MULTU : OP_MULT, 5'd0, a, b, 5'd0, 16'd0);
            if (rd != 5'd0) begin
               if (act == ACT_MULOU) begin
                  add_inst(OP_MFHI, 5'd1, 5'd0, 5'd0, 5'd0, 16'd0);
                  add_inst(OP_BEQ, 5'd0, 5'd1, 5'd0, 5'd0, BRANCH_IMM);
                  add_inst(OP_SLL, 5'd0, 5'd0, 5'd0, 5'd0, 16'd0);
                  add_inst(OP_BREAK, 5'd0, 5'd0, 5'd0, 5'd0, 16'd0);
               end else if (act == ACT_MULO) begin
                  // High word must equal the sign spread of the low word.
                  add_inst(OP_MFHI, 5'd1, 5'd0, 5'd0, 5'd0, 16'd0);
                  add_inst(OP_MFLO, rd, 5'd0, 5'd0, 5'd0, 16'd0);
                  add_inst(OP_SRA, rd, 5'd0, rd, SPREAD_SHAMT, 16'd0);
                  add_inst(OP_BEQ, 5'd0, 5'd1, rd, 5'd0, BRANCH_IMM);
                  add_inst(OP_SLL, 5'd0, 5'd0, 5'd0, 5'd0, 16'd0);
                  add_inst(OP_BREAK, 5'd0, 5'd0, 5'd0, 5'd0, 16'd0);
               end
               add_inst(OP_MFLO, rd, 5'd0, 5'd0, 5'd0, 16'd0);
            end
         end
         ACT_SLE, ACT_SLEU, ACT_SGE, ACT_SGEU: begin
            add_inst(OP_BNE, 5'd0, b, a, 5'd0, BRANCH_IMM);
            add_inst(OP_ORI, 5'd0, 5'd0, rd, 5'd0, 16'd1);
            add_inst(OP_BEQ, 5'd0, 5'd0, 5'd0, 5'd0, BRANCH_IMM);
            add_inst(OP_SLL, 5'd0, 5'd0, 5'd0, 5'd0, 16'd0);
            if (act == ACT_SLE || act == ACT_SLEU)
               add_inst(act == ACT_SLE ? OP_SLT : OP_SLTU, rd, a, b, 5'd0, 16'd0);
            else
               add_inst(act == ACT_SGE ? OP_SLT : OP_SLTU, rd, b, a, 5'd0, 16'd0);
         end
         ACT_SGT, ACT_SGTU: begin
            add_inst(act == ACT_SGT ? OP_SLT : OP_SLTU, rd, b, a, 5'd0, 16'd0);
         end
         ACT_SEQ, ACT_SNE: begin
            add_inst(OP_BEQ, 5'd0, b, a, 5'd0, BRANCH_IMM);
            add_inst(OP_ORI, 5'd0, 5'd0, rd, 5'd0, act == ACT_SEQ ? 16'd0 : 16'd1);
            add_inst(OP_BEQ, 5'd0, 5'd0, 5'd0, 5'd0, BRANCH_IMM);
            add_inst(OP_SLL, 5'd0, 5'd0, 5'd0, 5'd0, 16'd0);
            add_inst(OP_ORI, 5'd0, 5'd0, rd, 5'd0, act == ACT_SEQ ? 16'd1 : 16'd0);
         end
         default: ;
      endcase
      if (expected_insts.size() > first)
         expected_insts[expected_insts.size() - 1].last = 1'b1;
   endfunction

   function automatic void queue_op(logic [3:0] act, logic [4:0] dest, logic [4:0] a,
                                    logic [4:0] b, logic known, logic drain);
      pseudo_op_type p;
      p.action = act;
      p.dest   = dest;
      p.src_a  = a;
      p.src_b  = b;
      p.known  = known;
      p.drain  = drain;
      pending_ops.push_back(p);
   endfunction

   // Odds of starting an idle burst; zero means no idling. Idling rotates through
   // phases and stops near the end of the run.
   function automatic int idle_odds(int count, int span);
      if (pending_ops.size() < QUIET_TAIL)
         return 0;
      case ((count / span) % 3)
         0: return 0;
         1: return 3;
         default: return 12;
      endcase
   endfunction

   always @(posedge clock) begin : drive_requests
      pseudo_op_type next_op;
      int odds;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (req_valid) begin
            expand_pseudo_op(req_action, req_dest_reg, req_src_a_reg, req_src_b_reg,
                             req_divisor_known);
            n_accepted++;
         end
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (pending_ops.size() != 0 &&
                      !(pending_ops[0].drain && expected_insts.size() != 0)) begin
            next_op = pending_ops.pop_front();
            req_valid         <= 1'b1;
            req_action        <= next_op.action;
            req_dest_reg      <= next_op.dest;
            req_src_a_reg     <= next_op.src_a;
            req_src_b_reg     <= next_op.src_b;
            req_divisor_known <= next_op.known;
            odds = idle_odds(n_accepted, 40);
            if (odds != 0 && $urandom_range(1, odds) == 1)
               send_gap = $urandom_range(1, 10);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : check_results
      mips_inst_type want;
      int odds;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            n_results++;
            if (expected_insts.size() == 0) begin
               n_mismatches++;
               if (n_mismatches <= MAX_REPORTS) begin
                  $write("unexpected transaction: op=%0d rd=%0d rs=%0d rt=%0d ",
                         rsp_opcode, rsp_rd_field, rsp_rs_field, rsp_rt_field);
                  $display("sh=%0d imm=%0d last=%0b", rsp_shift_amount, rsp_immediate,
                           rsp_last);
               end
            end else begin
               want = expected_insts.pop_front();
               if (rsp_opcode !== want.op || rsp_rd_field !== want.rd ||
                   rsp_rs_field !== want.rs || rsp_rt_field !== want.rt ||
                   rsp_shift_amount !== want.shamt || rsp_immediate !== want.imm ||
                   rsp_last !== want.last) begin
                  n_mismatches++;
                  if (n_mismatches <= MAX_REPORTS) begin
                     $write("mismatch: expected op=%0d rd=%0d rs=%0d rt=%0d sh=%0d imm=%0d ",
                            want.op, want.rd, want.rs, want.rt, want.shamt,
                            $signed(want.imm));
                     $display("last=%0b, got op=%0d rd=%0d rs=%0d rt=%0d sh=%0d imm=%0d last=%0b",
                              want.last, rsp_opcode, rsp_rd_field, rsp_rs_field,
                              rsp_rt_field, rsp_shift_amount, rsp_immediate, rsp_last);
                  end
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            odds = idle_odds(n_results, 150);
            if (odds != 0 && $urandom_range(1, odds) == 1) begin
               stall_left = $urandom_range(0, 9);
               rsp_ready <= 1'b0;
            end else begin
               rsp_ready <= 1'b1;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= MAX_CYCLES) begin
         $display("[pseudo_instruction_expander_core] ERROR");
         $finish;
      end
   end

   initial begin : run_test
      pseudo_op_type p;
      int n_random;
      int pick;

      queue_op(ACT_DIV,   5'd5,  5'd31, 5'd31, 1'b0, 1'b0);
      queue_op(ACT_DIVU,  5'd31, 5'd0,  5'd7,  1'b0, 1'b0);
      queue_op(ACT_REM,   5'd1,  5'd2,  5'd3,  1'b0, 1'b0);
      queue_op(ACT_REMU,  5'd9,  5'd8,  5'd10, 1'b1, 1'b0);
      queue_op(ACT_DIV,   5'd0,  5'd4,  5'd5,  1'b0, 1'b0);
      queue_op(ACT_MUL,   5'd3,  5'd4,  5'd5,  1'b0, 1'b0);
      queue_op(ACT_MUL,   5'd0,  5'd31, 5'd0,  1'b0, 1'b0);
      queue_op(ACT_MULO,  5'd31, 5'd1,  5'd2,  1'b0, 1'b0);
      queue_op(ACT_MULO,  5'd0,  5'd3,  5'd31, 1'b1, 1'b0);
      queue_op(ACT_MULOU, 5'd7,  5'd6,  5'd31, 1'b0, 1'b0);
      queue_op(ACT_MULOU, 5'd0,  5'd0,  5'd0,  1'b0, 1'b0);
      queue_op(ACT_SLE,   5'd4,  5'd5,  5'd6,  1'b0, 1'b0);
      queue_op(ACT_SLEU,  5'd0,  5'd31, 5'd0,  1'b0, 1'b0);
      queue_op(ACT_SGT,   5'd2,  5'd3,  5'd4,  1'b0, 1'b0);
      queue_op(ACT_SGTU,  5'd31, 5'd31, 5'd31, 1'b1, 1'b0);
      queue_op(ACT_SGE,   5'd1,  5'd0,  5'd0,  1'b0, 1'b0);
      queue_op(ACT_SGEU,  5'd6,  5'd7,  5'd8,  1'b0, 1'b0);
      queue_op(ACT_SEQ,   5'd10, 5'd11, 5'd12, 1'b0, 1'b0);
      queue_op(ACT_SNE,   5'd0,  5'd13, 5'd14, 1'b1, 1'b0);
      queue_op(ACT_UNUSED, 5'd5, 5'd6,  5'd7,  1'b1, 1'b0);
      queue_op(ACT_DIV,   5'd0,  5'd9,  5'd0,  1'b1, 1'b0);
      // Holds off until every earlier transaction has come back.
      queue_op(ACT_DIVU,  5'd3,  5'd21, 5'd22, 1'b1, 1'b1);

      n_random = 0;
      while (n_random < RANDOM_OPS) begin
         p.action = 4'($urandom_range(0, 15));
         pick = $urandom_range(0, 11);
         if (pick == 0)
            p.dest = 5'd0;
         else if (pick == 1)
            p.dest = 5'd31;
         else
            p.dest = 5'($urandom_range(1, 30));
         p.src_a = 5'($urandom_range(0, 31));
         p.src_b = 5'($urandom_range(0, 31));
         p.known = 1'($urandom_range(0, 1));
         p.drain = ($urandom_range(0, 99) == 0);
         pending_ops.push_back(p);
         if (p.action != ACT_UNUSED)
            n_random++;
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (pending_ops.size() != 0 || req_valid || expected_insts.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (n_mismatches == 0 && expected_insts.size() == 0)
         $display("[pseudo_instruction_expander_core] OK");
      else
         $display("[pseudo_instruction_expander_core] ERROR");
      $finish;
   end

endmodule

>>> files.f
src/pie_pkg.sv
src/pseudo_instruction_expander_core.sv
tb/sv/testbench.sv
